>>> sv/tvps_pkg.sv
// Shared types and constants for the timed vibrator power sequencer.
`default_nettype none
package tvps_pkg;

  localparam int unsigned MIN_ON_MS        = 25;
  localparam int unsigned STANDBY_DELAY_MS = 1000;
  localparam int unsigned DURATION_BITS    = 16;

  localparam int unsigned DUR_W = 16;
  localparam int unsigned SBY_W = 10;

  localparam logic [DUR_W-1:0] DUR_LIMIT = (DURATION_BITS < DUR_W) ?
      DUR_W'((64'd1 << DURATION_BITS) - 64'd1) : {DUR_W{1'b1}};
  localparam logic [DUR_W-1:0] MIN_ON    = DUR_W'(MIN_ON_MS);
  localparam logic [SBY_W-1:0] SBY_DELAY = SBY_W'(STANDBY_DELAY_MS);

  localparam logic [15:0] STRONG_LEVEL = 16'd4;
  localparam logic [7:0]  DRIVE_NORMAL    = 8'h06;
  localparam logic [7:0]  DRIVE_STRONG    = 8'h0B;
  localparam logic [7:0]  DRIVE_LP_NORMAL = 8'h05;
  localparam logic [7:0]  DRIVE_LP_STRONG = 8'h08;

  typedef enum logic [1:0] {
    PWR_STANDBY = 2'd0,
    PWR_ON      = 2'd1,
    PWR_OFF     = 2'd2
  } power_state_t;

  typedef enum logic [1:0] {
    BUS_NONE  = 2'd0,
    BUS_FULL  = 2'd1,
    BUS_DRIVE = 2'd2
  } bus_write_t;

  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_TICK    = 1'b1
  } command_t;

  typedef enum logic {
    REG_INTENSITY = 1'b0,
    REG_LOW_POWER = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             command;
    logic [DUR_W-1:0] duration_ms;
  } cmd_word_t;

  typedef struct packed {
    logic             reset_line;
    logic             enable_line;
    logic [1:0]       bus_write;
    logic [7:0]       drive_byte;
    logic [DUR_W-1:0] remaining_ms;
    logic [1:0]       power_state;
  } res_word_t;

endpackage
`default_nettype wire

>>> sv/timed_vibrator_power_sequencer.sv
// Top level: vibration motor power sequencer with a registered result word.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one word per enable
//   request (command 0, duration_ms, 0 means stop) or one millisecond tick
//   (command 1). A word is taken at a clock edge with cmd_valid high and
//   cmd_stall low.
//   res channel (res_valid / res_stall / res) returns exactly one word per
//   command word: pin levels, the bus write kind, the drive byte, the off
//   countdown and the power state after that command.
//   The result sits in the output register on the cycle after the command
//   is taken. Throughput is one word per cycle; the whole step is a few
//   compares and one decrement per countdown. While res is stalled with a
//   word held, cmd_stall is high; a word taken in the same cycle as the held
//   one leaves keeps the flow at full rate. Configuration (cfg_write /
//   cfg_index / cfg_data) sets intensity level and low power mode; the user
//   writes it only while the block is idle, which the block does not check.
//   Synchronous reset puts the block in standby with both pins low, both
//   countdowns cleared, intensity 3, low power off and no result pending.
`default_nettype none
module timed_vibrator_power_sequencer (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic                    cfg_index,
  input  wire logic [15:0]             cfg_data,
  input  wire logic                    cmd_valid,
  output logic                         cmd_stall,
  input  wire tvps_pkg::cmd_word_t     cmd,
  output logic                         res_valid,
  input  wire logic                    res_stall,
  output tvps_pkg::res_word_t          res
);

  logic [15:0] intensity_level;
  logic        low_power_mode;

  tvps_pkg::power_state_t             state, state_next;
  logic [tvps_pkg::DUR_W-1:0]         off_count, off_count_next;
  logic [tvps_pkg::SBY_W-1:0]         standby_count, standby_count_next;
  logic                               stretched, stretched_next;
  logic                               reset_pin, reset_pin_next;
  logic                               enable_pin, enable_pin_next;
  tvps_pkg::bus_write_t               bus_next;
  tvps_pkg::res_word_t                res_next;
  logic                               res_valid_next;

  logic                               accept;
  logic [tvps_pkg::DUR_W-1:0]         dur;
  logic [7:0]                         drive_byte;

  assign cmd_stall = res_valid & res_stall;
  assign accept    = cmd_valid & ~cmd_stall;
  assign dur       = (cmd.duration_ms > tvps_pkg::DUR_LIMIT) ? tvps_pkg::DUR_LIMIT
                                                              : cmd.duration_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      intensity_level <= 16'd3;
      low_power_mode  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        tvps_pkg::REG_INTENSITY: intensity_level <= cfg_data;
        tvps_pkg::REG_LOW_POWER: low_power_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next state for one command word.
  always_comb begin
    state_next         = state;
    off_count_next     = off_count;
    standby_count_next = standby_count;
    stretched_next     = stretched;
    reset_pin_next     = reset_pin;
    enable_pin_next    = enable_pin;
    bus_next           = tvps_pkg::BUS_NONE;
    if (cmd.command == tvps_pkg::CMD_REQUEST) begin
      if (dur == '0) begin
        // Stop, unless a stretched short request is still running.
        if (!stretched) begin
          off_count_next = '0;
          if (state == tvps_pkg::PWR_ON) begin
            enable_pin_next    = 1'b0;
            state_next         = tvps_pkg::PWR_OFF;
            standby_count_next = tvps_pkg::SBY_DELAY;
          end
        end
      end else begin
        standby_count_next = '0;
        if (dur < tvps_pkg::MIN_ON) begin
          off_count_next = tvps_pkg::MIN_ON;
          stretched_next = 1'b1;
        end else begin
          off_count_next = dur;
          stretched_next = 1'b0;
        end
        if (state == tvps_pkg::PWR_STANDBY) begin
          reset_pin_next = 1'b1;
          bus_next       = tvps_pkg::BUS_FULL;
        end else begin
          bus_next = tvps_pkg::BUS_DRIVE;
        end
        enable_pin_next = 1'b1;
        state_next      = tvps_pkg::PWR_ON;
      end
    end else begin
      // Advance the standby countdown before the off countdown.
      if (standby_count != '0) begin
        standby_count_next = standby_count - 1'b1;
        if (standby_count_next == '0 && state == tvps_pkg::PWR_OFF) begin
          reset_pin_next = 1'b0;
          state_next     = tvps_pkg::PWR_STANDBY;
        end
      end
      if (off_count != '0) begin
        off_count_next = off_count - 1'b1;
        if (off_count_next == '0) begin
          stretched_next = 1'b0;
          if (state_next == tvps_pkg::PWR_ON) begin
            enable_pin_next    = 1'b0;
            state_next         = tvps_pkg::PWR_OFF;
            standby_count_next = tvps_pkg::SBY_DELAY;
          end
        end
      end
    end
  end

  // Result word and output register control.
  always_comb begin
    if (intensity_level == tvps_pkg::STRONG_LEVEL) begin
      drive_byte = low_power_mode ? tvps_pkg::DRIVE_LP_STRONG : tvps_pkg::DRIVE_STRONG;
    end else begin
      drive_byte = low_power_mode ? tvps_pkg::DRIVE_LP_NORMAL : tvps_pkg::DRIVE_NORMAL;
    end
    res_next.reset_line   = reset_pin_next;
    res_next.enable_line  = enable_pin_next;
    res_next.bus_write    = bus_next;
    res_next.drive_byte   = drive_byte;
    res_next.remaining_ms = off_count_next;
    res_next.power_state  = state_next;
    if (accept) begin
      res_valid_next = 1'b1;
    end else begin
      res_valid_next = res_valid & res_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tvps_pkg::PWR_STANDBY;
      off_count     <= '0;
      standby_count <= '0;
      stretched     <= 1'b0;
      reset_pin     <= 1'b0;
      enable_pin    <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
      if (accept) begin
        state         <= state_next;
        off_count     <= off_count_next;
        standby_count <= standby_count_next;
        stretched     <= stretched_next;
        reset_pin     <= reset_pin_next;
        enable_pin    <= enable_pin_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  a_enable_only_on: assert property (@(posedge clk) disable iff (rst)
    enable_pin |-> state == tvps_pkg::PWR_ON)
    else $error("enable pin driven outside the on state");

  a_standby_wait_only_off: assert property (@(posedge clk) disable iff (rst)
    (standby_count != '0) |-> state == tvps_pkg::PWR_OFF)
    else $error("standby countdown running outside the off state");

  a_powered_not_standby: assert property (@(posedge clk) disable iff (rst)
    (state != tvps_pkg::PWR_STANDBY) |-> reset_pin)
    else $error("chip held in reset while not in standby");

  a_stretched_only_on: assert property (@(posedge clk) disable iff (rst)
    stretched |-> (state == tvps_pkg::PWR_ON && off_count != '0))
    else $error("stretched mark set without a running on period");

  a_word_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted command produced no result word");

endmodule
`default_nettype wire
